[rtl/wpdh_pkg.sv]
// ----------------------------------------------------------------------------
// wpdh_pkg
// Shared constants and types of the weighted pair-distance histogram.
// ----------------------------------------------------------------------------
package wpdh_pkg;

   localparam int NUM_PAIR_TYPES = 4;
   localparam int NUM_BINS       = 128;
   localparam int STORE_DEPTH    = NUM_PAIR_TYPES * NUM_BINS;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int BIN_W          = $clog2(NUM_BINS);

   localparam int KIND_W      = 2;
   localparam int PAIR_W      = 2;
   localparam int DIST_W      = 24;
   localparam int WEIGHT_W    = 32;
   localparam int RBIN_W      = 7;
   localparam int BPU_W       = 16;
   localparam int PROD_W      = DIST_W + BPU_W;
   localparam int BIN_SHIFT   = 24;
   localparam int BIN_HI_W    = PROD_W - BIN_SHIFT;
   localparam int ENTRY_W     = 48;

   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 56;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 24'd655360;
   localparam logic [BPU_W-1:0]  BINS_PER_UNIT_RESET = 16'd2560;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DISTANCE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_PER_UNIT = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_UPDATE,
      ST_CLEAR
   } state_type;

endpackage

[rtl/wpdh_ram.sv]
// ----------------------------------------------------------------------------
// wpdh_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module wpdh_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/weighted_pair_distance_histogram.sv]
// ----------------------------------------------------------------------------
// weighted_pair_distance_histogram
// Bins weighted pair distances into a saturating 48-bit histogram per pair
// type, with single-entry read back and whole-store clear.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_tvalid/tready    | tuser kind, tdata sample
//  rsp_     | out       | rsp_tvalid/tready    | tdata entry and flags
//  csr_     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
//  One item is in flight at a time. An add or read that reaches the store has
//  its result registered after the bin map and then the RAM read and update,
//  and the next item is taken once that result is registered; an item that
//  leaves the store alone gives its result from the bin map step and then
//  frees the input. The registered read data of the RAM adds the update step.
//  A clear item sweeps all STORE_DEPTH (512) entries, one entry a cycle.
//  After reset the same sweep runs before the first item is taken.
//  A stalled result holds in the output register; the next item is still
//  accepted, and only its own result waits for the slot.
// ----------------------------------------------------------------------------
module weighted_pair_distance_histogram (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [1:0] pair_type, [25:2] distance, [57:26] weight, [64:58] read_bin
   input  logic [wpdh_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] kind
   input  logic [wpdh_pkg::KIND_W-1:0]          req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [47:0] entry_value, [48] counted, [49] out_of_range
   output logic [wpdh_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wpdh_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wpdh_pkg::CSR_DATA_W-1:0]      csr_data
);

   import wpdh_pkg::*;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;
   kind_type                kind_ff, kind_in;
   logic [PAIR_W-1:0]       pair_ff, pair_in;
   logic [WEIGHT_W-1:0]     weight_ff, weight_in;
   logic [RBIN_W-1:0]       rbin_ff, rbin_in;
   logic [PROD_W-1:0]       product_ff, product_in;
   logic                    skip_ff, skip_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [DIST_W-1:0]       max_distance_ff;
   logic [BPU_W-1:0]        bins_per_unit_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                    rsp_counted_ff, rsp_counted_in;
   logic                    rsp_oor_ff, rsp_oor_in;

   logic                    accept;
   logic                    out_free;
   logic [DIST_W-1:0]       req_distance;
   logic [BIN_HI_W-1:0]     bin_hi;
   logic                    bin_oor;
   logic                    rbin_oor;
   logic                    pair_oor;
   logic [ADDR_W-1:0]       add_addr;
   logic [ADDR_W-1:0]       read_addr;
   logic [ENTRY_W:0]        sum;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [ENTRY_W-1:0]      ram_wr_data;
   logic                    ram_rd_en;
   logic [ENTRY_W-1:0]      ram_rd_data;

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_distance = req_tdata[25:2];
   assign csr_ready    = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_oor_ff, rsp_counted_ff, rsp_value_ff};

   // bin = (distance * bins_per_unit) >> 24
   assign bin_hi    = product_ff[PROD_W-1:BIN_SHIFT];
   assign bin_oor   = 32'(bin_hi) >= NUM_BINS;
   assign rbin_oor  = 32'(rbin_ff) >= NUM_BINS;
   assign pair_oor  = 32'(pair_ff) >= NUM_PAIR_TYPES;
   assign add_addr  = ADDR_W'(ADDR_W'(pair_ff) * ADDR_W'(NUM_BINS))
                      + ADDR_W'(bin_hi[BIN_W-1:0]);
   assign read_addr = ADDR_W'(ADDR_W'(pair_ff) * ADDR_W'(NUM_BINS))
                      + ADDR_W'(rbin_ff);
   assign sum       = {1'b0, ram_rd_data} + (ENTRY_W+1)'(weight_ff);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      kind_in        = kind_ff;
      pair_in        = pair_ff;
      weight_in      = weight_ff;
      rbin_in        = rbin_ff;
      product_in     = product_ff;
      skip_in        = skip_ff;
      addr_in        = addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_counted_in = rsp_counted_ff;
      rsp_oor_in     = rsp_oor_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = addr_ff;
      ram_wr_data    = sum[ENTRY_W-1:0];
      ram_rd_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = kind_type'(req_tuser);
               pair_in    = req_tdata[1:0];
               weight_in  = req_tdata[57:26];
               rbin_in    = req_tdata[64:58];
               product_in = PROD_W'(req_distance) * PROD_W'(bins_per_unit_ff);
               skip_in    = req_distance >= max_distance_ff;
               state_in   = ST_MAP;
            end
         end
         ST_MAP: begin
            case (kind_ff)
               KIND_ADD: begin
                  if (skip_ff || bin_oor || pair_oor) begin
                     if (out_free) begin
                        rsp_valid_in   = 1'b1;
                        rsp_value_in   = '0;
                        rsp_counted_in = 1'b0;
                        rsp_oor_in     = !skip_ff;
                        state_in       = ST_IDLE;
                     end
                  end else begin
                     ram_rd_en = 1'b1;
                     addr_in   = add_addr;
                     state_in  = ST_UPDATE;
                  end
               end
               KIND_READ: begin
                  if (rbin_oor || pair_oor) begin
                     if (out_free) begin
                        rsp_valid_in   = 1'b1;
                        rsp_value_in   = '0;
                        rsp_counted_in = 1'b0;
                        rsp_oor_in     = 1'b1;
                        state_in       = ST_IDLE;
                     end
                  end else begin
                     ram_rd_en = 1'b1;
                     addr_in   = read_addr;
                     state_in  = ST_UPDATE;
                  end
               end
               KIND_CLEAR: begin
                  // report first, then sweep the store
                  if (out_free) begin
                     rsp_valid_in   = 1'b1;
                     rsp_value_in   = '0;
                     rsp_counted_in = 1'b0;
                     rsp_oor_in     = 1'b0;
                     clr_addr_in    = '0;
                     state_in       = ST_CLEAR;
                  end
               end
               default: begin
                  if (out_free) begin
                     rsp_valid_in   = 1'b1;
                     rsp_value_in   = '0;
                     rsp_counted_in = 1'b0;
                     rsp_oor_in     = 1'b0;
                     state_in       = ST_IDLE;
                  end
               end
            endcase
         end
         ST_UPDATE: begin
            // read data holds until the next read, so wait here for the slot
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (kind_ff == KIND_ADD) begin
                  ram_wr_en      = 1'b1;
                  ram_wr_data    = sum[ENTRY_W] ? '1 : sum[ENTRY_W-1:0];
                  rsp_value_in   = ram_wr_data;
                  rsp_counted_in = 1'b1;
                  rsp_oor_in     = sum[ENTRY_W];
               end else begin
                  rsp_value_in   = ram_rd_data;
                  rsp_counted_in = 1'b0;
                  rsp_oor_in     = 1'b0;
               end
            end
         end
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_addr_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         max_distance_ff  <= MAX_DISTANCE_RESET;
         bins_per_unit_ff <= BINS_PER_UNIT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_DISTANCE:  max_distance_ff  <= csr_data;
               CSR_BINS_PER_UNIT: bins_per_unit_ff <= csr_data[BPU_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      pair_ff        <= pair_in;
      weight_ff      <= weight_in;
      rbin_ff        <= rbin_in;
      product_ff     <= product_in;
      skip_ff        <= skip_in;
      addr_ff        <= addr_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_counted_ff <= rsp_counted_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

   wpdh_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_in),
      .rd_data (ram_rd_data)
   );

endmodule
